>>> rtl/bma_pkg.sv
// Package: shared constants, codes and request type for the block map allocator.
`timescale 1ns / 1ps
package bma_pkg;
  localparam int BLOCKS_PER_POOL = 1024;
  localparam int POOL_COUNT      = 3;
  localparam int IDX_W   = $clog2(BLOCKS_PER_POOL);
  localparam int NBLK_W  = IDX_W + 1;
  localparam int POOL_W  = 2;
  localparam int BSZ_W   = 13;
  localparam int REQ_W   = 23;
  localparam int OFF_W   = 22;
  localparam int ENT_W   = 11;
  localparam int ST_W    = 3;
  localparam int USE_W   = 10;
  localparam int RAM_DEPTH = POOL_COUNT * BLOCKS_PER_POOL;
  localparam int BSZ_MAX = 4096;
  localparam int PERMILLE = 1000;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO     = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTREADY = 3'd3;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [POOL_W-1:0] pool;
    logic [REQ_W-1:0]  req_bytes;
    logic [OFF_W-1:0]  free_offset;
    logic              bad_pool;
    logic              zero_size;
  } req_t;
endpackage

>>> rtl/bma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/bma_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module bma_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bma_pkg::REQ_W-1:0] a,
  input  logic [bma_pkg::BSZ_W-1:0] b,
  output logic                      done,
  output logic [bma_pkg::REQ_W-1:0] q,
  output logic [bma_pkg::BSZ_W-1:0] r
);
  localparam int CNT_W = $clog2(bma_pkg::REQ_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic [bma_pkg::BSZ_W:0]   rem;
  logic [bma_pkg::BSZ_W-1:0] dsr;
  logic [bma_pkg::BSZ_W:0]   shifted;
  logic                      ge;

  assign shifted = {rem[bma_pkg::BSZ_W-1:0], q[bma_pkg::REQ_W-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign r       = rem[bma_pkg::BSZ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(bma_pkg::REQ_W);
        rem <= '0;
        q   <= a;
        dsr <= b;
      end else if (cnt != '0) begin
        rem  <= ge ? shifted - {1'b0, dsr} : shifted;
        q    <= {q[bma_pkg::REQ_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end
endmodule

>>> rtl/bma_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module bma_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [47:0]                       s_tdata,
  input  logic [2:0]                        s_tuser,
  output logic                              q_valid,
  output bma_pkg::req_t                     q_data,
  input  logic                              q_pop
);
  bma_pkg::req_t slot [2];
  bma_pkg::req_t req;
  logic       wptr, rptr;
  logic [1:0] cnt;
  logic       push;

  always_comb begin
    req.op          = s_tuser[0];
    req.pool        = s_tuser[2:1];
    req.req_bytes   = s_tdata[22:0];
    req.free_offset = s_tdata[44:23];
    req.bad_pool    = {1'b0, s_tuser[2:1]} >= 3'(bma_pkg::POOL_COUNT);
    req.zero_size   = s_tdata[22:0] == '0;
  end

  assign s_tready = cnt != 2'd2;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = cnt != 2'd0;
  assign q_data   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      cnt <= cnt + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

>>> rtl/bma_back.sv
// Back end: table scan, run marking and clearing, usage count and result register.
`timescale 1ns / 1ps
module bma_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  bma_pkg::req_t              q_data,
  output logic                       q_pop,
  input  logic [bma_pkg::BSZ_W-1:0]  cfg_bsz [bma_pkg::POOL_COUNT],
  input  logic [bma_pkg::NBLK_W-1:0] cfg_nblk [bma_pkg::POOL_COUNT],
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bma_pkg::ST_W-1:0]   out_status,
  output logic [bma_pkg::OFF_W-1:0]  out_offset,
  output logic [bma_pkg::USE_W-1:0]  out_usage
);
  localparam int IW = bma_pkg::IDX_W;
  localparam int NW = bma_pkg::NBLK_W;
  localparam int BW = bma_pkg::BSZ_W;
  localparam int AW = $clog2(bma_pkg::RAM_DEPTH);
  localparam int NEED_W = bma_pkg::REQ_W + 1;
  localparam int PROD_W = NW + 10;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_DISP = 4'd3;
  localparam logic [3:0] S_DIVN = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_MARK = 4'd6;
  localparam logic [3:0] S_DIVF = 4'd7;
  localparam logic [3:0] S_FRD  = 4'd8;
  localparam logic [3:0] S_FWT  = 4'd9;
  localparam logic [3:0] S_FCLR = 4'd10;
  localparam logic [3:0] S_CNT  = 4'd11;
  localparam logic [3:0] S_MUL  = 4'd12;
  localparam logic [3:0] S_DIVU = 4'd13;

  logic [3:0]                 state;
  bma_pkg::req_t              cur;
  logic [BW-1:0]              bsz;
  logic [NW-1:0]              nblk;
  logic [BW+NW-1:0]           lim;
  logic                       fresh;
  logic [bma_pkg::POOL_COUNT-1:0] ready;
  logic [NW-1:0]              ptr;
  logic                       rd_v;
  logic [IW-1:0]              rd_idx;
  logic [NW-1:0]              run;
  logic [NEED_W-1:0]          need;
  logic [IW-1:0]              base;
  logic [NW-1:0]              mcnt;
  logic [NW-1:0]              nclr;
  logic [bma_pkg::ST_W-1:0]   status;
  logic [NW-1:0]              used;

  logic                       div_start, div_done;
  logic [bma_pkg::REQ_W-1:0]  div_a, div_q;
  logic [BW-1:0]              div_b, div_r;

  logic                       we, issue;
  logic [AW-1:0]              waddr, raddr;
  logic [bma_pkg::ENT_W-1:0]  wdata, rdata;
  logic [IW-1:0]              ridx;
  logic [NW-1:0]              run_n;
  logic                       clr_ok;
  logic [IW+BW-1:0]           boff_full;
  logic [BW-1:0]              bsz_raw, bsz_eff;
  logic [NW-1:0]              nblk_raw, nblk_eff;

  bma_ram #(.WIDTH(bma_pkg::ENT_W), .DEPTH(bma_pkg::RAM_DEPTH)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  bma_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(div_a), .b(div_b),
    .done(div_done), .q(div_q), .r(div_r)
  );

  always_comb begin
    bsz_raw  = cfg_bsz[q_data.pool];
    nblk_raw = cfg_nblk[q_data.pool];
    if (bsz_raw == '0) bsz_eff = BW'(1);
    else if (bsz_raw > BW'(bma_pkg::BSZ_MAX)) bsz_eff = BW'(bma_pkg::BSZ_MAX);
    else bsz_eff = bsz_raw;
    if (nblk_raw == '0) nblk_eff = NW'(1);
    else if (nblk_raw > NW'(bma_pkg::BLOCKS_PER_POOL)) nblk_eff = NW'(bma_pkg::BLOCKS_PER_POOL);
    else nblk_eff = nblk_raw;
  end

  assign run_n     = (rdata == '0) ? run + 1'b1 : '0;
  assign clr_ok    = (mcnt < nclr) && (({1'b0, base} + {1'b0, mcnt}) < {1'b0, nblk});
  assign boff_full = base * bsz;
  assign q_pop     = (state == S_IDLE) && q_valid && !out_valid;

  always_comb begin
    we    = 1'b0;
    waddr = {cur.pool, base};
    wdata = '0;
    issue = 1'b0;
    ridx  = ptr[IW-1:0];
    case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = {cur.pool, ptr[IW-1:0]};
      end
      S_SCAN: begin
        issue = ptr != '0;
        ridx  = IW'(ptr - 1'b1);
      end
      S_MARK: begin
        we    = 1'b1;
        waddr = {cur.pool, IW'({1'b0, base} + mcnt)};
        wdata = need[bma_pkg::ENT_W-1:0];
      end
      S_FRD: begin
        ridx = base;
      end
      S_FCLR: begin
        we    = clr_ok;
        waddr = {cur.pool, IW'({1'b0, base} + mcnt)};
      end
      S_CNT: begin
        issue = ptr < nblk;
      end
      default: begin
      end
    endcase
    raddr = {cur.pool, ridx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      rd_v      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rd_v      <= issue;
      rd_idx    <= ridx;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur    <= q_data;
            status <= bma_pkg::ST_OK;
            out_offset <= '0;
            bsz    <= bsz_eff;
            nblk   <= nblk_eff;
            if (q_data.bad_pool) begin
              out_valid  <= 1'b1;
              out_status <= bma_pkg::ST_RANGE;
              out_usage  <= '0;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          lim   <= nblk * bsz;
          fresh <= !ready[cur.pool];
          ptr   <= '0;
          state <= ready[cur.pool] ? S_DISP : S_CLR;
        end
        S_CLR: begin
          ptr <= ptr + 1'b1;
          if (ptr == NW'(bma_pkg::BLOCKS_PER_POOL - 1)) begin
            ready[cur.pool] <= 1'b1;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          ptr  <= '0;
          used <= '0;
          if (cur.op == bma_pkg::OP_ALLOC) begin
            if (cur.zero_size) begin
              status <= bma_pkg::ST_ZERO;
              state  <= S_CNT;
            end else begin
              div_a     <= cur.req_bytes;
              div_b     <= bsz;
              div_start <= 1'b1;
              state     <= S_DIVN;
            end
          end else if (fresh) begin
            status <= bma_pkg::ST_NOTREADY;
            state  <= S_CNT;
          end else if ({2'b0, cur.free_offset} >= lim) begin
            status <= bma_pkg::ST_RANGE;
            state  <= S_CNT;
          end else begin
            div_a     <= {1'b0, cur.free_offset};
            div_b     <= bsz;
            div_start <= 1'b1;
            state     <= S_DIVF;
          end
        end
        S_DIVN: begin
          if (div_done) begin
            need  <= {1'b0, div_q} + NEED_W'(div_r != '0);
            ptr   <= nblk;
            run   <= '0;
            rd_v  <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) ptr <= ptr - 1'b1;
          if (rd_v) begin
            run <= run_n;
            if ({{(NEED_W-NW){1'b0}}, run_n} == need) begin
              base  <= rd_idx;
              mcnt  <= '0;
              rd_v  <= 1'b0;
              state <= S_MARK;
            end else if (rd_idx == '0) begin
              status <= bma_pkg::ST_NOSPACE;
              ptr    <= '0;
              rd_v   <= 1'b0;
              state  <= S_CNT;
            end
          end
        end
        S_MARK: begin
          mcnt <= mcnt + 1'b1;
          if (mcnt == need[NW-1:0] - 1'b1) begin
            out_offset <= boff_full[bma_pkg::OFF_W-1:0];
            ptr   <= '0;
            rd_v  <= 1'b0;
            state <= S_CNT;
          end
        end
        S_DIVF: begin
          if (div_done) begin
            base  <= div_q[IW-1:0];
            state <= S_FRD;
          end
        end
        S_FRD: begin
          state <= S_FWT;
        end
        S_FWT: begin
          nclr  <= rdata;
          mcnt  <= '0;
          state <= S_FCLR;
        end
        S_FCLR: begin
          if (clr_ok) begin
            mcnt <= mcnt + 1'b1;
          end else begin
            ptr   <= '0;
            rd_v  <= 1'b0;
            state <= S_CNT;
          end
        end
        S_CNT: begin
          if (issue) ptr <= ptr + 1'b1;
          if (rd_v) begin
            if (rdata != '0) used <= used + 1'b1;
            if ({1'b0, rd_idx} == nblk - 1'b1) begin
              rd_v  <= 1'b0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          div_a     <= bma_pkg::REQ_W'(PROD_W'(used) * PROD_W'(bma_pkg::PERMILLE));
          div_b     <= BW'(nblk);
          div_start <= 1'b1;
          state     <= S_DIVU;
        end
        S_DIVU: begin
          if (div_done) begin
            out_valid  <= 1'b1;
            out_status <= status;
            out_usage  <= div_q[bma_pkg::USE_W-1:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule

>>> rtl/block_map_allocator.sv
// Top level: block table allocator with configuration registers.
`timescale 1ns / 1ps
// Block-table allocator for three pools of up to 1024 blocks. One request is
// handled at a time and gives one result. An allocate scans the pool's table
// from the top for a free run, writes the run and counts the pool's usage; a
// free clears its run and counts usage. The single table memory port handles
// one entry a cycle for the scan, run write and usage count, and a shared
// one-bit-a-cycle divider works out run lengths, free indices and usage. The
// first request to a pool after reset also clears that pool's table. A new
// request is queued while the previous one is worked on.
module block_map_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // request_bytes[22:0], free_offset[44:23], zero pad
  input  logic [2:0]  s_tuser,   // op[0], pool[2:1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // byte_offset[21:0], usage_permille[31:22]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [bma_pkg::BSZ_W-1:0]  cfg_bsz  [bma_pkg::POOL_COUNT];
  logic [bma_pkg::NBLK_W-1:0] cfg_nblk [bma_pkg::POOL_COUNT];
  logic                       q_valid, q_pop;
  bma_pkg::req_t              q_data;
  logic [bma_pkg::ST_W-1:0]   status;
  logic [bma_pkg::OFF_W-1:0]  boff;
  logic [bma_pkg::USE_W-1:0]  usage;
  logic [2:0]                 reg_idx;
  logic                       wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bma_pkg::POOL_COUNT; i++) begin
        cfg_bsz[i]  <= bma_pkg::BSZ_W'(64);
        cfg_nblk[i] <= bma_pkg::NBLK_W'(bma_pkg::BLOCKS_PER_POOL);
      end
    end else if (wr) begin
      if (reg_idx < 3'd3) begin
        cfg_bsz[reg_idx[1:0]] <= pwdata[bma_pkg::BSZ_W-1:0];
      end else if (reg_idx < 3'd6) begin
        cfg_nblk[2'(reg_idx - 3'd3)] <= pwdata[bma_pkg::NBLK_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < 3'd3) begin
      prdata = 32'(cfg_bsz[reg_idx[1:0]]);
    end else if (reg_idx < 3'd6) begin
      prdata = 32'(cfg_nblk[2'(reg_idx - 3'd3)]);
    end
  end

  bma_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  bma_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .cfg_bsz(cfg_bsz), .cfg_nblk(cfg_nblk),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_status(status), .out_offset(boff), .out_usage(usage)
  );

  assign m_tdata = {usage, boff};
  assign m_tuser = status;
endmodule

>>> bench/testbench.sv
// Testbench: checks block_map_allocator requests against a built-in allocator predictor.
`timescale 1ns / 1ps
module testbench;
  import bma_pkg::*;

  typedef struct {
    logic             op;
    logic [1:0]       pool;
    logic [REQ_W-1:0] req_bytes;
    logic [OFF_W-1:0] free_offset;
  } alloc_req_t;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] byte_offset;
    logic [USE_W-1:0] usage;
  } alloc_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // request_bytes[22:0], free_offset[44:23], zero pad
  logic [2:0]  s_tuser = '0;   // op[0], pool[2:1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // byte_offset[21:0], usage_permille[31:22]
  logic [2:0]  m_tuser;        // status[2:0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  block_map_allocator dut (.*);

  // predictor state
  int  block_tbl[POOL_COUNT][BLOCKS_PER_POOL];
  bit  pool_rdy[POOL_COUNT];
  int  bsz_reg[POOL_COUNT];
  int  nblk_reg[POOL_COUNT];

  alloc_req_t pending_reqs[$];
  alloc_res_t expected_res[$];
  alloc_req_t cur_req;
  int  snd_gap = 0;
  int  rcv_stall = 0;
  bit  long_done = 1'b0;
  bit  quiet = 1'b0;
  int  n_sent = 0;
  int  n_got = 0;
  int  fails = 0;
  int  st_cnt[8];

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(60_000_000);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int eff_bsz(int p);
    int v;
    v = bsz_reg[p];
    if (v < 1) v = 1;
    if (v > BSZ_MAX) v = BSZ_MAX;
    return v;
  endfunction

  function automatic int eff_nblk(int p);
    int v;
    v = nblk_reg[p];
    if (v < 1) v = 1;
    if (v > BLOCKS_PER_POOL) v = BLOCKS_PER_POOL;
    return v;
  endfunction

  function automatic void predict_alloc(alloc_req_t r);
    alloc_res_t e;
    int p, bs, nb, need, run, idx, n, used;
    bit fresh, found;
    e.status = ST_OK;
    e.byte_offset = '0;
    e.usage = '0;
    p = r.pool;
    if (p >= POOL_COUNT) begin
      e.status = ST_RANGE;
      expected_res.push_back(e);
      return;
    end
    bs = eff_bsz(p);
    nb = eff_nblk(p);
    fresh = 1'b0;
    if (!pool_rdy[p]) begin
      for (int i = 0; i < BLOCKS_PER_POOL; i++) block_tbl[p][i] = 0;
      pool_rdy[p] = 1'b1;
      fresh = 1'b1;
    end
    if (r.op == OP_ALLOC) begin
      if (r.req_bytes == 0) begin
        e.status = ST_ZERO;
      end else begin
        need = r.req_bytes / bs + ((r.req_bytes % bs) != 0 ? 1 : 0);
        run = 0;
        found = 1'b0;
        for (int k = nb; k > 0 && !found; k--) begin
          idx = k - 1;
          if (block_tbl[p][idx] == 0) run++; else run = 0;
          if (run == need) begin
            for (int i = 0; i < need; i++) block_tbl[p][idx + i] = need;
            e.byte_offset = OFF_W'(idx * bs);
            found = 1'b1;
          end
        end
        if (!found) e.status = ST_NOSPACE;
      end
    end else if (fresh) begin
      e.status = ST_NOTREADY;
    end else if (r.free_offset >= nb * bs) begin
      e.status = ST_RANGE;
    end else begin
      idx = r.free_offset / bs;
      n = block_tbl[p][idx];
      for (int i = 0; i < n && idx + i < nb; i++) block_tbl[p][idx + i] = 0;
    end
    used = 0;
    for (int i = 0; i < nb; i++) if (block_tbl[p][i] != 0) used++;
    e.usage = USE_W'((used * PERMILLE) / nb);
    expected_res.push_back(e);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      snd_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_alloc(cur_req);
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (snd_gap > 0) begin
          snd_gap <= snd_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {3'b0, cur_req.free_offset, cur_req.req_bytes};
          s_tuser <= {cur_req.pool, cur_req.op};
          if (!quiet && $urandom_range(0, 5) == 0) snd_gap <= $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    alloc_res_t e;
    if (rst) begin
      m_tready <= 1'b0;
      rcv_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_got++;
        if (expected_res.size() == 0) begin
          $error("unexpected result: status %0d", m_tuser);
          fails++;
        end else begin
          e = expected_res.pop_front();
          st_cnt[e.status]++;
          if (m_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_tuser);
            fails++;
          end
          if (m_tdata[21:0] !== e.byte_offset) begin
            $error("byte_offset: expected %0d, got %0d", e.byte_offset, m_tdata[21:0]);
            fails++;
          end
          if (m_tdata[31:22] !== e.usage) begin
            $error("usage_permille: expected %0d, got %0d", e.usage, m_tdata[31:22]);
            fails++;
          end
        end
      end
      if (rcv_stall > 0) begin
        rcv_stall <= rcv_stall - 1;
        m_tready <= 1'b0;
      end else if (n_got == 40 && !long_done) begin
        long_done <= 1'b1;
        rcv_stall <= 6000;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rcv_stall <= $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(logic op, int pool, int bytes, int off);
    alloc_req_t r;
    r.op = op;
    r.pool = pool[1:0];
    r.req_bytes = bytes[REQ_W-1:0];
    r.free_offset = off[OFF_W-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || s_tvalid || expected_res.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(int idx, int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < POOL_COUNT) bsz_reg[idx] = value & 32'h1FFF;
    else nblk_reg[idx - POOL_COUNT] = value & 32'h7FF;
    @(negedge clk);
  endtask

  task automatic set_pools(int b0, int b1, int b2, int n0, int n1, int n2);
    apb_write(0, b0);
    apb_write(1, b1);
    apb_write(2, b2);
    apb_write(3, n0);
    apb_write(4, n1);
    apb_write(5, n2);
  endtask

  task automatic random_reqs(int count);
    int p, bs, nb, k, kind;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, POOL_COUNT - 1);
      bs = eff_bsz(p);
      nb = eff_nblk(p);
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        k = $urandom_range(1, (nb / 3 > 1) ? nb / 3 : 1);
        push_req(OP_ALLOC, p, (kind == 0 && $urandom_range(0, 3) == 0) ? 0 :
                 (k - 1) * bs + $urandom_range(1, bs), 0);
      end else if (kind <= 7) begin
        push_req(OP_FREE, p, $urandom, $urandom_range(0, nb * bs - 1));
      end else if (kind == 8) begin
        push_req($urandom_range(0, 1), $urandom_range(0, 3), $urandom & 32'h7FFFFF,
                 $urandom & 32'h3FFFFF);
      end else begin
        push_req(OP_FREE, p, 0, (nb * bs + $urandom_range(0, 5000)) & 32'h3FFFFF);
      end
    end
  endtask

  initial begin
    for (int p = 0; p < POOL_COUNT; p++) begin
      bsz_reg[p] = 64;
      nblk_reg[p] = BLOCKS_PER_POOL;
      pool_rdy[p] = 1'b0;
      for (int i = 0; i < BLOCKS_PER_POOL; i++) block_tbl[p][i] = 0;
    end
    for (int i = 0; i < 8; i++) st_cnt[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset geometry: 64-byte blocks, full tables
    push_req(OP_FREE, 0, 0, 0);
    push_req(OP_ALLOC, 1, 0, 0);
    push_req(OP_ALLOC, 0, 1, 0);
    push_req(OP_ALLOC, 0, 4194304, 0);
    push_req(OP_ALLOC, 0, 32'h7FFFFF, 0);
    push_req(OP_ALLOC, 0, 4096, 0);
    push_req(OP_FREE, 0, 0, 1023 * 64 + 63);
    push_req(OP_FREE, 0, 0, 32'h3FFFFF);
    push_req(OP_FREE, 0, 0, 100);
    push_req(OP_ALLOC, 3, 1234, 0);
    push_req(OP_FREE, 3, 0, 32'h3FFFFF);
    push_req(OP_FREE, 2, 0, 0);
    push_req(OP_ALLOC, 2, 65536, 0);
    push_req(OP_ALLOC, 2, 1, 0);
    push_req(OP_FREE, 2, 0, 5000);
    push_req(OP_ALLOC, 1, 65535, 0);
    push_req(OP_ALLOC, 1, 64, 0);
    push_req(OP_FREE, 1, 0, 65535);
    push_req(OP_FREE, 1, 0, 65536);
    push_req(OP_ALLOC, 0, 32'h2AAAAA, 0);
    push_req(OP_FREE, 0, 0, 32'h155555);
    wait_idle();

    set_pools(1, 4096, 8191, 16, 8, 0);
    random_reqs(90);
    wait_idle();
    set_pools(0, 100, 7, 2047, 12, 20);
    random_reqs(80);
    wait_idle();
    set_pools(4096, 1, 33, 1, 24, 14);
    random_reqs(90);
    wait_idle();
    // resize pools under live runs; pool 1 shrinks so frees hit the table end
    set_pools(13, 4096, 1, 30, 2, 1024);
    random_reqs(80);
    wait_idle();
    set_pools(5, 64, 2, 10, 16, 6);
    random_reqs(90);
    wait_idle();
    quiet = 1'b1;
    random_reqs(90);
    wait_idle();
    repeat (300) @(posedge clk);

    $display("Covered %0d requests, %0d results over six pool geometries", n_sent, n_got);
    $display("status counts ok/nospace/zero/notready/range: %0d %0d %0d %0d %0d",
             st_cnt[0], st_cnt[1], st_cnt[2], st_cnt[3], st_cnt[4]);
    if (fails == 0 && expected_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
